[rtl/kae_pkg.sv]
// Shared types and constants for the keypad edge and auto-repeat block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package kae_pkg;

    localparam int KEY_COUNT    = 10;
    localparam int CNT_W        = 8;
    localparam int CFG_ADDR_W   = 1;
    localparam int CFG_DATA_W   = 8;
    localparam int S_TDATA_W    = ((KEY_COUNT + 7) / 8) * 8;
    localparam int M_TDATA_W    = (((4 * KEY_COUNT) + 7) / 8) * 8;

    typedef logic [KEY_COUNT-1:0]  key_set_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

    // Configuration register indexes
    localparam cfg_addr_t REG_REPEAT_DELAY  = 1'd0;
    localparam cfg_addr_t REG_REPEAT_PERIOD = 1'd1;

    localparam cnt_t DELAY_RESET  = 8'd60;
    localparam cnt_t PERIOD_RESET = 8'd30;

    // Item kinds carried on s_tuser
    typedef enum logic {
        KIND_SCAN = 1'b0,
        KIND_READ = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t    kind;
        key_set_t raw_keys;
    } item_t;

    typedef struct packed {
        key_set_t repeat_keys;
        key_set_t up_keys;
        key_set_t down_keys;
        key_set_t held_keys;
    } result_t;

    // Handshake between the input stage, the core and the result stage
    typedef struct packed {
        logic item_valid;
        logic advance;
    } flow_t;

endpackage

[rtl/keypad_edge_and_autorepeat.sv]
// Top level of the keypad edge and auto-repeat block.
// Depends on kae_pkg, kae_in_stage, kae_core and kae_out_stage.
`timescale 1ns / 1ps

// Key scanner for a 10-key pad. Each input word is either a scan (s_tuser = 0) carrying
// the raw active-low key lines, or a read (s_tuser = 1) that returns the flags and clears
// the sticky down set. Every word yields exactly one result word: held keys, sticky down
// keys (as they were before a read clears them), sticky up keys and the pressed or
// auto-repeated keys. A change in held keys reloads the repeat countdown with
// repeat_delay (register 0, reset 60); while the delay is nonzero, each scan decrements
// it, and on reaching zero it reloads with repeat_period (register 1, reset 30) and ORs
// the held keys into the repeat set. A zero delay stops auto-repeat. The block takes one
// word per clock while m_tready does not stall the result register; a word reaches the m_
// side through the input register and the result register with the state update between
// them. s_tready drops only while the input register is full and the result register is
// stalled by m_tready. Write configuration only while the block is idle.
module keypad_edge_and_autorepeat
    import kae_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // Configuration write port
    input  logic                  cfg_we,
    input  cfg_addr_t             cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    // Input words
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,  // [9:0] raw_keys, rest zero
    input  logic                  s_tuser,  // [0] kind: 0 scan, 1 read

    // Result words
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata   // held, down, up, repeat keys, low to high
);

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    advance;
    flow_t   flow;
    result_t result;
    result_t m_result;

    // Unpack the input word; extra tdata bits are padding
    assign s_item.kind     = kind_t'(s_tuser);
    assign s_item.raw_keys = s_tdata[KEY_COUNT-1:0];

    kae_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    assign flow.item_valid = item_valid;
    assign flow.advance    = advance;

    // State update: commits only when the word moves into the result register
    kae_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .flow      (flow),
        .item      (item),
        .result    (result)
    );

    kae_out_stage u_out_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .advance    (advance),
        .result     (result),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_result   (m_result)
    );

    // Pack the result fields, held keys in the lowest bits
    assign m_tdata = M_TDATA_W'(m_result);

    // A word moved out of the input register shows up on the result side next cycle
    a_advance_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("advanced word did not reach the result register");

    // A held word waits in the input register while the result side is stalled
    a_in_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        item_valid && !advance |=> item_valid && $stable(item))
        else $error("input register lost a stalled word");

    // A released key is never held, pressed or repeating at the same time
    a_up_disjoint: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_result.up_keys & m_result.held_keys) == '0) &&
                     ((m_result.up_keys & m_result.down_keys) == '0) &&
                     ((m_result.up_keys & m_result.repeat_keys) == '0))
        else $error("up set overlaps held, down or repeat set");

endmodule

[rtl/kae_in_stage.sv]
// Input register of the keypad block: holds one accepted word until the core takes it.
// Depends on kae_pkg.
`timescale 1ns / 1ps

module kae_in_stage
    import kae_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  item_t s_item,
    input  logic  advance,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Accept when empty or when the held word moves on this cycle
    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[rtl/kae_core.sv]
// Key state and auto-repeat update of the keypad block, plus the two configuration registers.
// Depends on kae_pkg.
`timescale 1ns / 1ps

module kae_core
    import kae_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  cfg_addr_t             cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  flow_t                 flow,
    input  item_t                 item,
    output result_t               result
);

    key_set_t held_reg,   held_next;
    key_set_t down_reg,   down_next;
    key_set_t up_reg,     up_next;
    key_set_t rep_reg,    rep_next;
    cnt_t     cnt_reg,    cnt_next;
    cnt_t     delay_reg;
    cnt_t     period_reg;

    key_set_t scan_held;
    key_set_t pressed;
    key_set_t released;
    key_set_t scan_down;
    key_set_t scan_up;
    key_set_t scan_rep;
    cnt_t     cnt_load;
    cnt_t     cnt_dec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg  <= DELAY_RESET;
            period_reg <= PERIOD_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_REPEAT_DELAY:  delay_reg  <= cfg_wdata;
                REG_REPEAT_PERIOD: period_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        scan_held = ~item.raw_keys;
        pressed   = scan_held & ~held_reg;
        released  = held_reg & ~scan_held;
        scan_down = (down_reg | pressed) & ~released;
        scan_up   = (up_reg | released) & ~pressed;
        scan_rep  = (rep_reg | pressed) & ~released;

        // Reload on any change of held keys, then count down while enabled
        cnt_load  = (scan_held != held_reg) ? delay_reg : cnt_reg;
        cnt_dec   = cnt_load - 1'b1;

        held_next = held_reg;
        down_next = down_reg;
        up_next   = up_reg;
        rep_next  = rep_reg;
        cnt_next  = cnt_reg;
        result    = '{repeat_keys: rep_reg, up_keys: up_reg,
                      down_keys: down_reg, held_keys: held_reg};

        if (item.kind == KIND_SCAN) begin
            held_next = scan_held;
            down_next = scan_down;
            up_next   = scan_up;
            rep_next  = scan_rep;
            cnt_next  = cnt_load;
            if (delay_reg != '0) begin
                cnt_next = cnt_dec;
                if (cnt_dec == '0) begin
                    cnt_next = period_reg;
                    rep_next = scan_rep | scan_held;
                end
            end
            result = '{repeat_keys: rep_next, up_keys: up_next,
                       down_keys: down_next, held_keys: held_next};
        end else begin
            down_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
            down_reg <= '0;
            up_reg   <= '0;
            rep_reg  <= '0;
            cnt_reg  <= DELAY_RESET;
        end else if (flow.item_valid && flow.advance) begin
            held_reg <= held_next;
            down_reg <= down_next;
            up_reg   <= up_next;
            rep_reg  <= rep_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

[rtl/kae_out_stage.sv]
// Result register of the keypad block: holds one result word until the sink takes it.
// Depends on kae_pkg.
`timescale 1ns / 1ps

module kae_out_stage
    import kae_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    item_valid,
    output logic    advance,
    input  result_t result,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // Load when empty or when the held result drains this cycle
    assign advance = item_valid && (!valid_reg || m_ready);

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

[dv/kae_flag_checker.sv]
// Checker for the keypad edge and auto-repeat block: tracks key state, predicts flag words.
// Depends on kae_pkg; instantiated beside the block by tb_keypad_edge_and_autorepeat.
`timescale 1ns / 1ps

module kae_flag_checker
    import kae_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  cfg_addr_t             cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [9:0] raw_keys, rest zero
    input  logic                  s_tuser,   // [0] kind
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,   // held, down, up, repeat keys, low to high
    output int                    fail_count,
    output int                    pending_words
);

    key_set_t held_keys;
    key_set_t last_keys;
    key_set_t down_keys;
    key_set_t up_keys;
    key_set_t repeat_keys;
    cnt_t     countdown;
    cnt_t     delay_reg;
    cnt_t     period_reg;
    result_t  expected_flags[$];

    initial begin
        fail_count    = 0;
        pending_words = 0;
    end

    task automatic report(input string msg);
        $display("%0t ns: mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        result_t  want;
        result_t  got;
        key_set_t pressed;
        key_set_t released;
        if (!aresetn) begin
            held_keys   = '0;
            last_keys   = '0;
            down_keys   = '0;
            up_keys     = '0;
            repeat_keys = '0;
            countdown   = DELAY_RESET;
            delay_reg   = DELAY_RESET;
            period_reg  = PERIOD_RESET;
            expected_flags.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_addr == REG_REPEAT_DELAY)
                    delay_reg = cfg_wdata;
                else if (cfg_addr == REG_REPEAT_PERIOD)
                    period_reg = cfg_wdata;
            end

            // compare the departing word against the oldest prediction
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata);
                if (expected_flags.size() == 0) begin
                    report($sformatf("result word %h with nothing outstanding", m_tdata));
                end else begin
                    want = expected_flags.pop_front();
                    if (got.held_keys != want.held_keys)
                        report($sformatf("held_keys got %h want %h",
                                         got.held_keys, want.held_keys));
                    if (got.down_keys != want.down_keys)
                        report($sformatf("down_keys got %h want %h",
                                         got.down_keys, want.down_keys));
                    if (got.up_keys != want.up_keys)
                        report($sformatf("up_keys got %h want %h",
                                         got.up_keys, want.up_keys));
                    if (got.repeat_keys != want.repeat_keys)
                        report($sformatf("repeat_keys got %h want %h",
                                         got.repeat_keys, want.repeat_keys));
                end
            end

            if (s_tvalid && s_tready) begin
                if (kind_t'(s_tuser) == KIND_SCAN) begin
                    last_keys   = held_keys;
                    held_keys   = ~s_tdata[KEY_COUNT-1:0];
                    pressed     = held_keys & ~last_keys;
                    released    = last_keys & ~held_keys;
                    down_keys   = (down_keys | pressed) & ~released;
                    repeat_keys = (repeat_keys | pressed) & ~released;
                    up_keys     = (up_keys | released) & ~pressed;
                    if (held_keys != last_keys)
                        countdown = delay_reg;
                    if (delay_reg != '0) begin
                        countdown = countdown - 1'b1;
                        if (countdown == '0) begin
                            countdown   = period_reg;
                            repeat_keys = repeat_keys | held_keys;
                        end
                    end
                end
                want.held_keys   = held_keys;
                want.down_keys   = down_keys;
                want.up_keys     = up_keys;
                want.repeat_keys = repeat_keys;
                if (kind_t'(s_tuser) == KIND_READ)
                    down_keys = '0;
                expected_flags.push_back(want);
            end
        end
        pending_words = expected_flags.size();
    end

endmodule

[dv/tb_keypad_edge_and_autorepeat.sv]
// Top of the keypad edge and auto-repeat testbench: clock, reset, scan and read words,
// register writes and the verdict. Depends on kae_pkg, kae_flag_checker and the block.
`timescale 1ns / 1ps

module tb_keypad_edge_and_autorepeat;
    import kae_pkg::*;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    cfg_addr_t             cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // [9:0] raw_keys, rest zero
    logic                  s_tuser;   // [0] kind: 0 scan, 1 read
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // held, down, up, repeat keys, low to high

    int fail_count;
    int pending_words;

    // chance in a hundred that the sender idles / the receiver stalls on a cycle
    int send_idle;
    int recv_stall;

    keypad_edge_and_autorepeat dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    kae_flag_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending_words (pending_words)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // Drive m_tready from the falling edge; the stall rate follows the current phase.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall);
    end

    // Hard stop: far beyond the slowest legal run of all phases.
    initial begin
        #2_000_000;
        $display("tb_keypad_edge_and_autorepeat NOT OK");
        $finish;
    end

    // Offer one word and hold it until the block takes it. Called and returns just after
    // a falling edge, so every input moves on falling edges only.
    task automatic send_word(input kind_t kind, input key_set_t raw);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(S_TDATA_W-KEY_COUNT){1'b0}}, raw};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Drop valid and wait until every predicted word has come back, then let the pipeline
    // settle so a register write cannot overlap work in flight.
    task automatic drain;
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_words != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_addr_t idx, input cnt_t value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Random key activity shaped as holds: pick a key pattern, keep scanning it for a
    // while (sometimes long enough to cross the repeat delay and several periods), and
    // sprinkle reads with junk in the raw field, which the block must ignore.
    task automatic press_and_hold(input int words);
        int       left;
        int       hold_len;
        int       pick;
        key_set_t raw;
        left = words;
        while (left > 0) begin
            pick = $urandom_range(99);
            if (pick < 50)
                raw = key_set_t'($urandom);
            else if (pick < 75)
                raw = ~(key_set_t'(1) << $urandom_range(KEY_COUNT-1));
            else if (pick < 90)
                raw = '1;
            else
                raw = '0;
            if ($urandom_range(7) == 0)
                hold_len = $urandom_range(40, 300);
            else
                hold_len = $urandom_range(1, 12);
            if (hold_len > left)
                hold_len = left;
            repeat (hold_len) begin
                if ($urandom_range(99) < 15)
                    send_word(KIND_READ, key_set_t'($urandom));
                else
                    send_word(KIND_SCAN, raw);
            end
            left -= hold_len;
        end
    endtask

    initial begin
        aresetn    = 1'b0;
        cfg_we     = 1'b0;
        cfg_addr   = REG_REPEAT_DELAY;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tuser    = KIND_SCAN;
        s_tdata    = '0;
        m_tready   = 1'b0;
        send_idle  = 0;
        recv_stall = 0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed words at the reset delay and period: no keys, all keys, reads that
        // clear the down set (a second read shows it empty), partial releases, a full
        // release, a read carrying all-zero raw lines, and single-key presses.
        send_word(KIND_SCAN, 10'h3FF);
        send_word(KIND_SCAN, 10'h000);
        send_word(KIND_READ, 10'h3FF);
        send_word(KIND_READ, 10'h3FF);
        send_word(KIND_SCAN, 10'h3FE);
        send_word(KIND_SCAN, 10'h155);
        send_word(KIND_SCAN, 10'h2AA);
        send_word(KIND_READ, 10'h3FF);
        send_word(KIND_SCAN, 10'h3FF);
        send_word(KIND_READ, 10'h000);
        send_word(KIND_SCAN, 10'h1FF);
        send_word(KIND_SCAN, 10'h1FF);
        send_word(KIND_SCAN, 10'h3FF);
        send_word(KIND_READ, 10'h155);

        // Phase 0: reset registers, no idling on either side.
        press_and_hold(225);
        drain();

        // Phase 1: zero delay stops auto-repeat; zero period too. Sender mostly idle.
        write_reg(REG_REPEAT_DELAY, 8'd0);
        write_reg(REG_REPEAT_PERIOD, 8'd0);
        send_idle  = 79;
        recv_stall = 0;
        press_and_hold(225);
        drain();

        // Phase 2: short delay with zero period, so the countdown wraps through 255
        // between repeats on long holds. Receiver mostly stalled.
        write_reg(REG_REPEAT_DELAY, 8'd2);
        send_idle  = 0;
        recv_stall = 79;
        press_and_hold(225);
        drain();

        // Phase 3: both registers at their maximum; light idling on both sides.
        write_reg(REG_REPEAT_DELAY, 8'd255);
        write_reg(REG_REPEAT_PERIOD, 8'd255);
        send_idle  = 12;
        recv_stall = 12;
        press_and_hold(225);
        drain();

        // Phase 4: delay and period of one, repeating on every held scan; full rate.
        write_reg(REG_REPEAT_DELAY, 8'd1);
        write_reg(REG_REPEAT_PERIOD, 8'd1);
        send_idle  = 0;
        recv_stall = 0;
        press_and_hold(225);
        drain();

        // Phase 5: small random delay and period.
        write_reg(REG_REPEAT_DELAY, cnt_t'($urandom_range(1, 12)));
        write_reg(REG_REPEAT_PERIOD, cnt_t'($urandom_range(0, 12)));
        send_idle  = 12;
        recv_stall = 12;
        press_and_hold(225);

        // Let the last words out without stalls, then settle.
        recv_stall = 0;
        drain();
        if (fail_count == 0)
            $display("tb_keypad_edge_and_autorepeat OK");
        else
            $display("tb_keypad_edge_and_autorepeat NOT OK");
        $finish;
    end

endmodule
